>>> design/hill_cipher_mod29_defines.svh
// ---------------------------------------------------------------------------
// hill_cipher_mod29 assertion macros
// Concurrent assertion helpers for the cipher RTL; empty under SYNTH.
// ---------------------------------------------------------------------------
`ifndef HILL_CIPHER_MOD29_DEFINES_SVH
`define HILL_CIPHER_MOD29_DEFINES_SVH

`ifndef SYNTH
// Checked on every rising edge of clk_i, disabled while rst_ni is low.
`define HCM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge of clk_i, reset included.
`define HCM_ASSERT_NORST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define HCM_ASSERT(name, prop, msg)
`define HCM_ASSERT_NORST(name, prop, msg)
`endif

`endif

>>> design/hcm_pkg.sv
// ---------------------------------------------------------------------------
// hcm_pkg
// Types, constants and mod 29 helper functions for the Hill cipher block.
// ---------------------------------------------------------------------------
package hcm_pkg;

  localparam int BLOCK_SIZE = 3;
  localparam int MATRIX_DIM = 3;
  localparam int BUF_DEPTH  = BLOCK_SIZE - 1;
  localparam int SYM_W      = 5;
  localparam int CHAR_W     = 8;
  localparam int KEY_W      = 45;
  localparam int CFG_IDX_W  = 2;
  localparam int FILL_W     = 2;
  localparam int RES_IDX_W  = $clog2(BLOCK_SIZE);
  localparam int SETTLE_W   = 3;
  localparam int ACC_W      = 14;

  // Cycles from a configuration write until the effective key is registered.
  localparam logic [SETTLE_W-1:0] KEY_LATENCY = SETTLE_W'(5);

  localparam logic [KEY_W-1:0] KEY_RESET = 45'd1099512676353;

  localparam logic [SYM_W-1:0] MODULUS      = 5'd29;
  localparam logic [SYM_W-1:0] SYM_SPACE    = 5'd26;
  localparam logic [SYM_W-1:0] SYM_PERIOD   = 5'd27;
  localparam logic [SYM_W-1:0] SYM_QUESTION = 5'd28;
  localparam logic [10:0]      MOD_SQ       = 11'd841;

  // floor(x / 29) == (x * 565) >> 14 for every x below 2**14.
  localparam logic [23:0] MOD_RECIP = 24'd565;
  localparam int          MOD_SHIFT = 14;

  localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PERIOD   = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_QUESTION = 8'h3F;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z  = 8'h7A;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_ENTRIES  = 2'd0,
    CFG_DECRYPT_MODE = 2'd1
  } cfg_idx_e;

  typedef logic [SYM_W-1:0] sym_t;
  typedef sym_t [MATRIX_DIM-1:0] sym_row_t;
  typedef sym_row_t [MATRIX_DIM-1:0] key_mat_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              message_end;
  } hcm_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              run_last;
  } hcm_out_t;

  function automatic sym_t mod29(input logic [ACC_W-1:0] x);
    logic [23:0]      prod;
    logic [9:0]       quo;
    logic [ACC_W-1:0] rem;
    prod = {10'd0, x} * MOD_RECIP;
    quo  = prod[23:MOD_SHIFT];
    rem  = x - ACC_W'({4'd0, quo} * {9'd0, MODULUS});
    return rem[SYM_W-1:0];
  endfunction

  function automatic sym_t reduce_entry(input sym_t e);
    return (e >= MODULUS) ? e - MODULUS : e;
  endfunction

  function automatic sym_t neg29(input sym_t e);
    return (e == '0) ? '0 : MODULUS - e;
  endfunction

  function automatic sym_t minor2(input sym_t a, input sym_t b, input sym_t c,
                                  input sym_t d);
    logic [10:0] ad;
    logic [10:0] bc;
    logic [10:0] sum;
    ad  = {6'd0, a} * {6'd0, d};
    bc  = {6'd0, b} * {6'd0, c};
    sum = ad + MOD_SQ - bc;
    return mod29({3'd0, sum});
  endfunction

  // Multiplicative inverse mod 29; zero has none and maps to zero.
  function automatic sym_t inv29(input sym_t d);
    sym_t r;
    case (d)
      5'd1:    r = 5'd1;
      5'd2:    r = 5'd15;
      5'd3:    r = 5'd10;
      5'd4:    r = 5'd22;
      5'd5:    r = 5'd6;
      5'd6:    r = 5'd5;
      5'd7:    r = 5'd25;
      5'd8:    r = 5'd11;
      5'd9:    r = 5'd13;
      5'd10:   r = 5'd3;
      5'd11:   r = 5'd8;
      5'd12:   r = 5'd17;
      5'd13:   r = 5'd9;
      5'd14:   r = 5'd27;
      5'd15:   r = 5'd2;
      5'd16:   r = 5'd20;
      5'd17:   r = 5'd12;
      5'd18:   r = 5'd21;
      5'd19:   r = 5'd26;
      5'd20:   r = 5'd16;
      5'd21:   r = 5'd18;
      5'd22:   r = 5'd4;
      5'd23:   r = 5'd24;
      5'd24:   r = 5'd23;
      5'd25:   r = 5'd7;
      5'd26:   r = 5'd19;
      5'd27:   r = 5'd14;
      5'd28:   r = 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic sym_t sym_of_char(input logic [CHAR_W-1:0] ch);
    sym_t s;
    if (ch == CHAR_SPACE) begin
      s = SYM_SPACE;
    end else if (ch == CHAR_PERIOD) begin
      s = SYM_PERIOD;
    end else if (ch == CHAR_QUESTION) begin
      s = SYM_QUESTION;
    end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
      s = SYM_W'(ch - CHAR_UPPER_A);
    end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
      s = SYM_W'(ch - CHAR_LOWER_A);
    end else begin
      s = SYM_SPACE;
    end
    return s;
  endfunction

  function automatic logic [CHAR_W-1:0] char_of_sym(input sym_t s);
    logic [CHAR_W-1:0] ch;
    if (s == SYM_SPACE) begin
      ch = CHAR_SPACE;
    end else if (s == SYM_PERIOD) begin
      ch = CHAR_PERIOD;
    end else if (s == SYM_QUESTION) begin
      ch = CHAR_QUESTION;
    end else if (s > SYM_QUESTION) begin
      ch = CHAR_UPPER_A + {3'd0, s - SYM_SPACE};
    end else begin
      ch = CHAR_UPPER_A + {3'd0, s};
    end
    return ch;
  endfunction

  // One row of the key times the block, mod 29.
  function automatic sym_t dot_row(input sym_row_t m_row, input sym_row_t blk);
    logic [ACC_W-1:0] acc;
    acc = '0;
    for (int c = 0; c < BLOCK_SIZE; c++) begin
      acc = acc + ACC_W'({5'd0, m_row[c]} * {5'd0, blk[c]});
    end
    return mod29(acc);
  endfunction

endpackage

>>> design/hill_cipher_mod29.sv
// ---------------------------------------------------------------------------
// hill_cipher_mod29
// Hill cipher over a 29-symbol alphabet with a 3x3 key, streaming characters.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid_i/in_stall_o   | hcm_in_t  {char_in, message_end}
//  out     | output    | out_valid_o/out_stall_i | hcm_out_t {char_out, run_last}
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One input character is taken per cycle. A character that completes a block
// (or ends the message) moves the block to a holding register; when the
// result register is free the key multiply fills it, and it issues BLOCK_SIZE
// characters, one per cycle while the output does not stall, so a plain
// stream runs at one character a cycle. After reset and after every
// configuration write the input stalls while the effective key pipeline
// settles; otherwise it stalls only when a finished block waits and the
// result register cannot take it. An output stall holds the result register.
//
module hill_cipher_mod29 import hcm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hcm_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hcm_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [KEY_W-1:0]     cfg_data_i
);

`include "hill_cipher_mod29_defines.svh"

  localparam logic [FILL_W-1:0]    FILL_FULL = FILL_W'(BLOCK_SIZE - 1);
  localparam logic [RES_IDX_W-1:0] RES_LAST  = RES_IDX_W'(BLOCK_SIZE - 1);

  // Configuration registers.
  logic [KEY_W-1:0]    key_entries_q;
  logic                decrypt_mode_q;
  logic                cfg_we;
  logic [SETTLE_W-1:0] settle_cnt_q;
  logic                key_ready;
  key_mat_t            key_mat;

  // Partial block and full block holding register.
  sym_t                buf_q [BUF_DEPTH];
  logic [FILL_W-1:0]   fill_count_q;
  sym_row_t            blk_d, blk_q;
  logic                blk_valid_q;

  // Result register, drained one character per transaction.
  logic [CHAR_W-1:0]    res_chars_q [BLOCK_SIZE];
  logic [RES_IDX_W-1:0] res_idx_q;
  logic                 res_valid_q;

  logic in_accept;
  logic out_accept;
  logic emit;
  logic res_last;
  logic res_free;
  logic res_load;
  sym_t sym_in;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_entries_q  <= KEY_RESET;
      decrypt_mode_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_KEY_ENTRIES:  key_entries_q  <= cfg_data_i;
        CFG_DECRYPT_MODE: decrypt_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The key pipeline runs freely; this counter marks when its output is
  // consistent with the configuration registers again.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_cnt_q <= KEY_LATENCY;
    end else if (cfg_we) begin
      settle_cnt_q <= KEY_LATENCY;
    end else if (settle_cnt_q != '0) begin
      settle_cnt_q <= settle_cnt_q - SETTLE_W'(1);
    end
  end

  assign key_ready = (settle_cnt_q == '0);

  hcm_keygen u_keygen (
    .clk_i          (clk_i),
    .key_entries_i  (key_entries_q),
    .decrypt_mode_i (decrypt_mode_q),
    .key_o          (key_mat)
  );

  // Handshake. The stall depends on internal state and the output stall,
  // never on payload.
  assign res_last   = (res_idx_q == RES_LAST);
  assign out_accept = res_valid_q & ~out_stall_i;
  assign res_free   = ~res_valid_q | (out_accept & res_last);
  assign res_load   = blk_valid_q & res_free;
  assign in_stall_o = ~key_ready | (blk_valid_q & ~res_free);
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign sym_in = sym_of_char(in_data_i.char_in);
  assign emit   = in_data_i.message_end | (fill_count_q == FILL_FULL);

  // Block assembly: buffered codes first, then the new code, then space
  // padding for a message that ends inside a block.
  always_comb begin
    for (int i = 0; i < MATRIX_DIM; i++) begin
      blk_d[i] = SYM_SPACE;
      if (FILL_W'(i) == fill_count_q) begin
        blk_d[i] = sym_in;
      end
    end
    for (int j = 0; j < BUF_DEPTH; j++) begin
      if (FILL_W'(j) < fill_count_q) begin
        blk_d[j] = buf_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_count_q <= '0;
    end else if (in_accept) begin
      fill_count_q <= emit ? '0 : fill_count_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && !emit) begin
      for (int j = 0; j < BUF_DEPTH; j++) begin
        if (FILL_W'(j) == fill_count_q) begin
          buf_q[j] <= sym_in;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_valid_q <= 1'b0;
    end else if (in_accept && emit) begin
      blk_valid_q <= 1'b1;
    end else if (res_load) begin
      blk_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      blk_q <= blk_d;
    end
  end

  // Key multiply between the block register and the result register.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      for (int r = 0; r < BLOCK_SIZE; r++) begin
        res_chars_q[r] <= char_of_sym(dot_row(key_mat[r], blk_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_idx_q   <= '0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
      res_idx_q   <= '0;
    end else if (out_accept) begin
      if (res_last) begin
        res_valid_q <= 1'b0;
      end else begin
        res_idx_q <= res_idx_q + RES_IDX_W'(1);
      end
    end
  end

  assign out_valid_o         = res_valid_q;
  assign out_data_o.char_out = res_chars_q[res_idx_q];
  assign out_data_o.run_last = res_last;

  `HCM_ASSERT_NORST(a_fill_range, !rst_ni || fill_count_q <= FILL_FULL, "fill count past block size")
  `HCM_ASSERT(a_blk_hold, blk_valid_q && !res_free |=> blk_valid_q && $stable(blk_q), "waiting block lost")
  `HCM_ASSERT(a_res_drain, out_accept && res_last && !blk_valid_q |=> !res_valid_q, "result not drained")
  `HCM_ASSERT(a_settle_restart, cfg_we |=> settle_cnt_q == KEY_LATENCY, "key settle not restarted")

endmodule

>>> design/hcm_keygen.sv
// ---------------------------------------------------------------------------
// hcm_keygen
// Pipelined build of the effective key: reduced key or its inverse mod 29.
// ---------------------------------------------------------------------------
module hcm_keygen import hcm_pkg::*; (
  input  logic             clk_i,
  input  logic [KEY_W-1:0] key_entries_i,
  input  logic             decrypt_mode_i,
  output key_mat_t         key_o
);

  key_mat_t k_d, k_q;
  key_mat_t adj_d, adj_q;
  key_mat_t m_d, m_q;
  sym_t     det_d, det_q;
  sym_t     dinv_q;

  // Entries reduced mod 29.
  always_comb begin
    for (int r = 0; r < MATRIX_DIM; r++) begin
      for (int c = 0; c < MATRIX_DIM; c++) begin
        k_d[r][c] = reduce_entry(key_entries_i[SYM_W*(MATRIX_DIM*r+c) +: SYM_W]);
      end
    end
  end

  // Adjugate from the 2x2 minors.
  always_comb begin
    adj_d = '0;
    if (BLOCK_SIZE == 2) begin
      adj_d[0][0] = k_q[1][1];
      adj_d[0][1] = neg29(k_q[0][1]);
      adj_d[1][0] = neg29(k_q[1][0]);
      adj_d[1][1] = k_q[0][0];
    end else begin
      for (int r = 0; r < MATRIX_DIM; r++) begin
        for (int c = 0; c < MATRIX_DIM; c++) begin
          adj_d[c][r] = minor2(k_q[(r == 2) ? 0 : r + 1][(c == 2) ? 0 : c + 1],
                               k_q[(r == 2) ? 0 : r + 1][(c == 0) ? 2 : c - 1],
                               k_q[(r == 0) ? 2 : r - 1][(c == 2) ? 0 : c + 1],
                               k_q[(r == 0) ? 2 : r - 1][(c == 0) ? 2 : c - 1]);
        end
      end
    end
  end

  always_comb begin
    logic [ACC_W-1:0] acc;
    acc = '0;
    if (BLOCK_SIZE == 2) begin
      det_d = minor2(k_q[0][0], k_q[0][1], k_q[1][0], k_q[1][1]);
    end else begin
      for (int c = 0; c < MATRIX_DIM; c++) begin
        acc = acc + ACC_W'({5'd0, k_q[0][c]} * {5'd0, adj_q[c][0]});
      end
      det_d = mod29(acc);
    end
  end

  always_comb begin
    for (int r = 0; r < MATRIX_DIM; r++) begin
      for (int c = 0; c < MATRIX_DIM; c++) begin
        if (decrypt_mode_i) begin
          m_d[r][c] = mod29(ACC_W'({5'd0, dinv_q} * {5'd0, adj_q[r][c]}));
        end else begin
          m_d[r][c] = k_q[r][c];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    adj_q  <= adj_d;
    det_q  <= det_d;
    dinv_q <= inv29(det_q);
    m_q    <= m_d;
  end

  assign key_o = m_q;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: Hill cipher mod 29 testbench
// The testbench streams ASCII characters into the cipher and checks every
// cipher character against a mod 29 matrix predictor kept in a scoreboard.
// It runs over several keys in both modes and under several idling patterns.
// ----------------------------------------------------------------------------
module tb import hcm_pkg::*; ();

  localparam int unsigned ALPHABET   = 29;
  localparam int unsigned SPACE_CODE = 26;
  localparam int          STALL_LIMIT = 5000;
  localparam int          PHASE_CHARS = 52;

  // --------------------------------------------------------------------------
  // The scoreboard predicts the cipher characters of every accepted input
  // transaction and checks each output transaction against the oldest one.
  // --------------------------------------------------------------------------
  class cipher_scoreboard;
    logic [KEY_W-1:0] key_bits;
    bit               decrypt;
    int unsigned      sym_buf[2];
    int unsigned      fill;
    int unsigned      key_mat[3][3];
    hcm_out_t         expected_chars[$];
    int               failures;

    function new();
      key_bits = KEY_RESET;
      decrypt  = 1'b0;
      sym_buf  = '{0, 0};
      fill     = 0;
      failures = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [KEY_W-1:0] value);
      case (idx)
        CFG_KEY_ENTRIES: begin
          key_bits = value;
        end
        CFG_DECRYPT_MODE: begin
          decrypt = value[0];
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned to_sym(logic [CHAR_W-1:0] ch);
      if (ch == CHAR_SPACE) return SPACE_CODE;
      if (ch == CHAR_PERIOD) return SPACE_CODE + 1;
      if (ch == CHAR_QUESTION) return SPACE_CODE + 2;
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) return ch - CHAR_UPPER_A;
      if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) return ch - CHAR_LOWER_A;
      return SPACE_CODE;
    endfunction

    function logic [CHAR_W-1:0] to_char(int unsigned s);
      if (s == SPACE_CODE) return CHAR_SPACE;
      if (s == SPACE_CODE + 1) return CHAR_PERIOD;
      if (s == SPACE_CODE + 2) return CHAR_QUESTION;
      return CHAR_UPPER_A + CHAR_W'(s % 26);
    endfunction

    function int unsigned cross2(int unsigned a, int unsigned b, int unsigned c,
                                 int unsigned d);
      return (a * d + ALPHABET * ALPHABET - b * c) % ALPHABET;
    endfunction

    // Effective key: the raw entries reduced mod 29, or in decrypt mode the
    // inverse determinant times the adjugate (all zeros when singular).
    function void build_key_mat();
      int unsigned k[3][3];
      int unsigned adj[3][3];
      int unsigned det;
      int unsigned dinv;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          k[r][c]   = key_bits[5*(3*r+c) +: 5] % ALPHABET;
          adj[r][c] = 0;
        end
      end
      if (!decrypt) begin
        key_mat = k;
        return;
      end
      det = 0;
      if (BLOCK_SIZE == 2) begin
        adj[0][0] = k[1][1];
        adj[0][1] = (ALPHABET - k[0][1]) % ALPHABET;
        adj[1][0] = (ALPHABET - k[1][0]) % ALPHABET;
        adj[1][1] = k[0][0];
        det = cross2(k[0][0], k[0][1], k[1][0], k[1][1]);
      end else begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            adj[c][r] = cross2(k[(r+1)%3][(c+1)%3], k[(r+1)%3][(c+2)%3],
                               k[(r+2)%3][(c+1)%3], k[(r+2)%3][(c+2)%3]);
          end
        end
        for (int c = 0; c < 3; c++) begin
          det = (det + k[0][c] * adj[c][0]) % ALPHABET;
        end
      end
      dinv = 0;
      for (int unsigned x = 1; x < ALPHABET; x++) begin
        if ((det * x) % ALPHABET == 1) dinv = x;
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          key_mat[r][c] = (dinv * adj[r][c]) % ALPHABET;
        end
      end
    endfunction

    function void note_char(hcm_in_t item);
      int unsigned s;
      int unsigned blk[3];
      int unsigned acc;
      int unsigned n;
      hcm_out_t    res;
      s = to_sym(item.char_in);
      if (fill + 1 < BLOCK_SIZE && !item.message_end) begin
        sym_buf[fill & 1] = s;
        fill = (fill + 1) & 3;
        return;
      end
      // A short final block is padded with spaces.
      blk = '{SPACE_CODE, SPACE_CODE, SPACE_CODE};
      n = 0;
      while (n < fill && n < BLOCK_SIZE - 1) begin
        blk[n] = sym_buf[n & 1];
        n++;
      end
      blk[n] = s;
      fill = 0;
      build_key_mat();
      for (int r = 0; r < BLOCK_SIZE; r++) begin
        acc = 0;
        for (int c = 0; c < BLOCK_SIZE; c++) begin
          acc = (acc + key_mat[r][c] * blk[c]) % ALPHABET;
        end
        res.char_out = to_char(acc);
        res.run_last = (r == BLOCK_SIZE - 1);
        expected_chars.push_back(res);
      end
    endfunction

    function void check_char(hcm_out_t got);
      hcm_out_t want;
      if (expected_chars.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual char_out=%h run_last=%b",
                 $time, got.char_out, got.run_last);
        return;
      end
      want = expected_chars.pop_front();
      if (got.char_out !== want.char_out) begin
        failures++;
        $display("%0t: char_out expected %h, actual %h", $time, want.char_out,
                 got.char_out);
      end
      if (got.run_last !== want.run_last) begin
        failures++;
        $display("%0t: run_last expected %b, actual %b", $time, want.run_last,
                 got.run_last);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the signals around the block. Every input of the block
  // starts at a known value.
  // --------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  hcm_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  hcm_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0]     cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  cipher_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hill_cipher_mod29 DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // The receiver decides its stall at the falling edge, independent of valid.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: all three channels are sampled at the rising edge. Register
  // writes go to the scoreboard's copy of the configuration, accepted input
  // transactions to the predictor and output transactions to the checker.
  // The watchdog ends the run when nothing moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_idx_e'(cfg_index), cfg_data);
      if (in_valid && !in_stall) sb.note_char(in_data);
      if (out_valid && !out_stall) sb.check_char(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
          (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. Each one starts and ends just after a falling edge. A
  // character that is presented stays on the bus until it is accepted.
  // --------------------------------------------------------------------------
  task automatic push_char(input logic [CHAR_W-1:0] ch, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid            = 1'b1;
    in_data.char_in     = ch;
    in_data.message_end = last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Waits until every predicted character has come out.
  task automatic hold_for_drain();
    in_valid = 1'b0;
    while (sb.expected_chars.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // A character that only fills the buffer gives no output, so after the
  // drain the task keeps the inputs idle before the configuration may change.
  task automatic settle_idle();
    hold_for_drain();
    repeat (2 * KEY_LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [KEY_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly letters of either case, with spaces, punctuation and stray bytes.
  function automatic logic [CHAR_W-1:0] message_char();
    int pick;
    pick = $urandom_range(9);
    if (pick <= 4) return CHAR_UPPER_A + CHAR_W'($urandom_range(25));
    if (pick <= 6) return CHAR_LOWER_A + CHAR_W'($urandom_range(25));
    if (pick == 7) return CHAR_SPACE;
    if (pick == 8) return $urandom_range(1) ? CHAR_PERIOD : CHAR_QUESTION;
    return CHAR_W'($urandom_range(255));
  endfunction

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      push_char(message_char(), i == len - 1);
    end
  endtask

  // Key entries are mostly in range; now and then one is above 28.
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] key;
    key = '0;
    for (int e = 0; e < 9; e++) begin
      key[5*e +: 5] = ($urandom_range(7) == 0) ? 5'($urandom_range(29, 31))
                                               : 5'($urandom_range(28));
    end
    return key;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  logic [CHAR_W-1:0] probe_chars[15] = '{
    CHAR_UPPER_A, CHAR_UPPER_Z, CHAR_LOWER_A, CHAR_LOWER_Z, CHAR_SPACE,
    CHAR_PERIOD, CHAR_QUESTION, 8'h00, 8'hFF, CHAR_UPPER_A - 8'd1,
    CHAR_UPPER_Z + 8'd1, CHAR_LOWER_A - 8'd1, CHAR_LOWER_Z + 8'd1, "H", "i"
  };

  initial begin
    int  sent;
    int  len;
    bit  paused;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, under the identity key that reset leaves: the edges of
    // each character class, then a message ending after one symbol, after
    // two, and exactly on a full block.
    foreach (probe_chars[i]) push_char(probe_chars[i], 1'b0);
    push_char("H", 1'b1);
    push_char("H", 1'b0);
    push_char("I", 1'b1);
    push_char("Q", 1'b0);
    push_char("R", 1'b0);
    push_char("S", 1'b1);

    // All-ones key: every entry is above 28, and the reduced matrix is
    // singular, so decrypting gives only 'A'.
    settle_idle();
    write_cfg(CFG_KEY_ENTRIES, '1);
    write_cfg(CFG_DECRYPT_MODE, KEY_W'(1));
    push_char("A", 1'b0);
    push_char("B", 1'b0);
    push_char("C", 1'b1);

    // All-zero key in encrypt mode.
    settle_idle();
    write_cfg(CFG_KEY_ENTRIES, '0);
    write_cfg(CFG_DECRYPT_MODE, KEY_W'(0));
    push_char("x", 1'b1);

    // Random part: eight phases, alternating mode, each idling pattern twice.
    // Most traffic is whole messages; the rest are lone random bytes with a
    // random end flag. Halfway through each phase the sender waits for the
    // output to drain.
    for (int ph = 0; ph < 8; ph++) begin
      settle_idle();
      write_cfg(CFG_KEY_ENTRIES, random_key());
      write_cfg(CFG_DECRYPT_MODE, KEY_W'(ph % 2));
      case ((ph / 2) % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
        end
      endcase
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_CHARS) begin
        if (!paused && sent >= PHASE_CHARS / 2) begin
          paused = 1'b1;
          hold_for_drain();
        end
        if ($urandom_range(5) == 0) begin
          push_char(CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
          sent++;
        end else begin
          len = $urandom_range(1, 12);
          send_message(len);
          sent += len;
        end
      end
    end

    // Let everything drain, then leave a short tail for stray output.
    hold_for_drain();
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/hcm_pkg.sv
design/hcm_keygen.sv
design/hill_cipher_mod29.sv
dv/tb.sv
